// ===== rtl/i2c_master_register_access_assert.svh =====
// Assertion helpers for the RTL. Each macro expects signals named clock
// and reset in the scope where it is used.
`ifndef I2C_MASTER_REGISTER_ACCESS_ASSERT_SVH
`define I2C_MASTER_REGISTER_ACCESS_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2CM_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("i2cm assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define I2CM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("i2cm assertion failed");

`endif

// ===== rtl/i2cm_pkg.sv =====
`timescale 1ns / 1ps

package i2cm_pkg;

   // Actions carried on the request word.
   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_WRITE = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_DEVICE_ADDRESS = 2'd0;
   localparam logic [1:0] CSR_STRETCH_ENABLE = 2'd1;
   localparam logic [1:0] CSR_HALF_PERIOD    = 2'd2;

   localparam logic [7:0] HALF_PERIOD_RESET = 8'd4;
   localparam logic       RW_READ           = 1'b1;
   localparam logic       RW_WRITE          = 1'b0;

   typedef struct packed {
      logic [6:0] device_address;
      logic       stretch_enable;
      logic [7:0] half_period_ticks;
   } cfg_type;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] reg_index;
      logic [7:0] write_value;
      logic       scl_sense;
      logic       sda_sense;
   } req_type;

   typedef struct packed {
      logic       scl_pull_low;
      logic       sda_pull_low;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_value;
      logic       all_acked;
   } rsp_type;

   // Byte shifted out for a given byte slot of the transaction.
   function automatic logic [7:0] byte_to_send(input logic [1:0] step,
                                               input logic       wr,
                                               input logic [6:0] addr,
                                               input logic [7:0] reg_v,
                                               input logic [7:0] val);
      logic [7:0] result;
      case (step)
         2'd0:    result = {addr, RW_WRITE};
         2'd1:    result = reg_v;
         2'd2:    result = wr ? val : {addr, RW_READ};
         default: result = 8'd0;
      endcase
      return result;
   endfunction

endpackage

// ===== rtl/i2cm_csr.sv =====
`timescale 1ns / 1ps

module i2cm_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_data,
   output i2cm_pkg::cfg_type cfg
);
   import i2cm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DEVICE_ADDRESS: cfg_in.device_address    = csr_data[6:0];
            CSR_STRETCH_ENABLE: cfg_in.stretch_enable    = csr_data[0];
            CSR_HALF_PERIOD:    cfg_in.half_period_ticks = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address    <= 7'd0;
         cfg_ff.stretch_enable    <= 1'b0;
         cfg_ff.half_period_ticks <= HALF_PERIOD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/i2cm_seq.sv =====
`timescale 1ns / 1ps

module i2cm_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  i2cm_pkg::req_type req,
   input  i2cm_pkg::cfg_type cfg,
   output i2cm_pkg::rsp_type rsp
);
   import i2cm_pkg::*;
   `include "i2c_master_register_access_assert.svh"

   localparam logic [3:0] PH_IDLE   = 4'd0;
   localparam logic [3:0] PH_ST_A   = 4'd1;
   localparam logic [3:0] PH_ST_B   = 4'd2;
   localparam logic [3:0] PH_ST_C   = 4'd3;
   localparam logic [3:0] PH_BIT_LO = 4'd4;
   localparam logic [3:0] PH_BIT_HI = 4'd5;
   localparam logic [3:0] PH_RS_A   = 4'd6;
   localparam logic [3:0] PH_SP_A   = 4'd7;
   localparam logic [3:0] PH_SP_B   = 4'd8;
   localparam logic [3:0] PH_SP_C   = 4'd9;

   logic [3:0] phase_ff, phase_in;
   logic [3:0] bit_count_ff, bit_count_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] tick_timer_ff, tick_timer_in;
   logic [1:0] byte_step_ff, byte_step_in;
   logic       is_write_ff, is_write_in;
   logic       ack_ff, ack_in;
   logic [7:0] read_byte_ff, read_byte_in;
   logic [7:0] saved_reg_ff, saved_reg_in;
   logic [7:0] saved_value_ff, saved_value_in;

   logic [7:0] limit;
   logic [7:0] timer_inc;
   logic [1:0] step_inc;
   logic [1:0] load_step;
   logic       load;
   logic       hold;
   logic       receiving_now;
   logic       receiving_next;
   logic       done;
   logic       scl_low;
   logic       sda_low;

   // A zero half period behaves as a single tick.
   assign limit         = (cfg.half_period_ticks == 8'd0) ? 8'd1 : cfg.half_period_ticks;
   assign timer_inc     = tick_timer_ff + 8'd1;
   assign step_inc      = byte_step_ff + 2'd1;
   assign receiving_now = !is_write_ff && (byte_step_ff == 2'd3);
   assign hold          = (phase_ff == PH_BIT_HI) && cfg.stretch_enable && !req.scl_sense;

   always_comb begin
      phase_in       = phase_ff;
      bit_count_in   = bit_count_ff;
      shift_in       = shift_ff;
      tick_timer_in  = tick_timer_ff;
      byte_step_in   = byte_step_ff;
      is_write_in    = is_write_ff;
      ack_in         = ack_ff;
      read_byte_in   = read_byte_ff;
      saved_reg_in   = saved_reg_ff;
      saved_value_in = saved_value_ff;
      load           = 1'b0;
      load_step      = byte_step_ff;
      done           = 1'b0;

      if (step) begin
         if (phase_ff == PH_IDLE) begin
            if (req.action == ACT_READ || req.action == ACT_WRITE) begin
               is_write_in    = (req.action == ACT_WRITE);
               saved_reg_in   = req.reg_index;
               saved_value_in = req.write_value;
               byte_step_in   = 2'd0;
               bit_count_in   = 4'd0;
               ack_in         = 1'b1;
               tick_timer_in  = 8'd0;
               phase_in       = PH_ST_A;
            end
         end else if (!hold) begin
            if (timer_inc >= limit) begin
               tick_timer_in = 8'd0;
               unique case (phase_ff)
                  PH_ST_A:   phase_in = PH_ST_B;
                  PH_ST_B:   phase_in = PH_ST_C;
                  PH_ST_C:   load = 1'b1;
                  PH_BIT_LO: phase_in = PH_BIT_HI;
                  PH_BIT_HI: begin
                     if (bit_count_ff < 4'd8) begin
                        // SDA is sampled on the last tick of the high half.
                        shift_in     = {shift_ff[6:0], receiving_now & req.sda_sense};
                        bit_count_in = bit_count_ff + 4'd1;
                        phase_in     = PH_BIT_LO;
                     end else if (receiving_now) begin
                        read_byte_in = shift_ff;
                        phase_in     = PH_SP_A;
                     end else begin
                        if (is_write_ff) begin
                           ack_in = ack_ff & ~req.sda_sense;
                        end
                        byte_step_in = step_inc;
                        if (is_write_ff && step_inc == 2'd3) begin
                           phase_in = PH_SP_A;
                        end else if (!is_write_ff && step_inc == 2'd2) begin
                           phase_in = PH_RS_A;
                        end else begin
                           load      = 1'b1;
                           load_step = step_inc;
                        end
                     end
                  end
                  PH_RS_A:   phase_in = PH_ST_A;
                  PH_SP_A:   phase_in = PH_SP_B;
                  PH_SP_B:   phase_in = PH_SP_C;
                  default: begin
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                  end
               endcase
            end else begin
               tick_timer_in = timer_inc;
            end
         end
      end

      if (load) begin
         shift_in     = byte_to_send(load_step, is_write_ff, cfg.device_address,
                                     saved_reg_ff, saved_value_ff);
         bit_count_in = 4'd0;
         phase_in     = PH_BIT_LO;
      end
   end

   // Line levels follow the segment the sequencer is in after this tick.
   assign receiving_next = !is_write_in && (byte_step_in == 2'd3);

   always_comb begin
      scl_low = 1'b0;
      sda_low = 1'b0;
      unique case (phase_in) inside
         PH_ST_B, PH_SP_B:  sda_low = 1'b1;
         PH_ST_C, PH_SP_A: begin
            scl_low = 1'b1;
            sda_low = 1'b1;
         end
         PH_RS_A:           scl_low = 1'b1;
         PH_BIT_LO, PH_BIT_HI: begin
            scl_low = (phase_in == PH_BIT_LO);
            if (bit_count_in < 4'd8 && !receiving_next) begin
               sda_low = ~shift_in[7];
            end
         end
         default: ;
      endcase
   end

   assign rsp.scl_pull_low = scl_low;
   assign rsp.sda_pull_low = sda_low;
   assign rsp.busy_res     = (phase_in != PH_IDLE);
   assign rsp.done_res     = done;
   assign rsp.read_value   = read_byte_in;
   assign rsp.all_acked    = ack_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         bit_count_ff   <= 4'd0;
         shift_ff       <= 8'd0;
         tick_timer_ff  <= 8'd0;
         byte_step_ff   <= 2'd0;
         is_write_ff    <= 1'b0;
         ack_ff         <= 1'b1;
         read_byte_ff   <= 8'd0;
         saved_reg_ff   <= 8'd0;
         saved_value_ff <= 8'd0;
      end else begin
         phase_ff       <= phase_in;
         bit_count_ff   <= bit_count_in;
         shift_ff       <= shift_in;
         tick_timer_ff  <= tick_timer_in;
         byte_step_ff   <= byte_step_in;
         is_write_ff    <= is_write_in;
         ack_ff         <= ack_in;
         read_byte_ff   <= read_byte_in;
         saved_reg_ff   <= saved_reg_in;
         saved_value_ff <= saved_value_in;
      end
   end

   `I2CM_ASSERT_IMPL(a_bit_count_range, 1'b1, bit_count_ff <= 4'd8)
   `I2CM_ASSERT_NEXT(a_done_to_idle, step && done, phase_ff == PH_IDLE)
   `I2CM_ASSERT_NEXT(a_start_clears_ack,
                     step && phase_ff == PH_IDLE && (req.action == ACT_READ || req.action == ACT_WRITE),
                     phase_ff == PH_ST_A && ack_ff && byte_step_ff == 2'd0)

endmodule

// ===== rtl/i2c_master_register_access.sv =====
`timescale 1ns / 1ps

// Register-access I2C master driven one tick per request word. Every accepted
// request word advances the bus sequencer by one tick and yields exactly one
// response word, so the block takes a word every cycle; each word goes through
// the request register, then the response register, and the only stall is
// back-pressure on the response side. Bus timing is counted in ticks: each SCL
// level lasts half_period_ticks words (one word when that is zero), longer
// while clock stretching is enabled and the slave holds SCL low. Action 1 runs
// a register read, action 2 a register write; actions sent while busy are
// ignored. Configuration is written through the csr_ port and should only
// change while no transaction is running.
module i2c_master_register_access (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] reg_index, [15:8] write_value, [16] scl_sense, [17] sda_sense
   input  logic [23:0] req_tdata,
   // [1:0] action
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] scl_pull_low, [1] sda_pull_low, [2] busy_res, [3] done_res,
   // [11:4] read_value, [12] all_acked
   output logic [15:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);
   import i2cm_pkg::*;

   cfg_type cfg;
   req_type req_word;
   req_type req_ff;
   rsp_type rsp_word;
   rsp_type rsp_ff;
   logic    req_valid_ff, req_valid_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    out_free;
   logic    step;

   assign req_word.action      = req_tuser;
   assign req_word.reg_index   = req_tdata[7:0];
   assign req_word.write_value = req_tdata[15:8];
   assign req_word.scl_sense   = req_tdata[16];
   assign req_word.sda_sense   = req_tdata[17];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step       = req_valid_ff && out_free;
   assign req_tready = !req_valid_ff || step;

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_tvalid && req_tready) begin
         req_valid_in = 1'b1;
      end else if (step) begin
         req_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_ff <= req_word;
      end
      if (step) begin
         rsp_ff <= rsp_word;
      end
   end

   i2cm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   i2cm_seq u_seq (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (req_ff),
      .cfg   (cfg),
      .rsp   (rsp_word)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_ff.all_acked, rsp_ff.read_value, rsp_ff.done_res,
                        rsp_ff.busy_res, rsp_ff.sda_pull_low, rsp_ff.scl_pull_low};

endmodule

// ===== dv/tb_i2c_master_register_access.sv =====
`timescale 1ns / 1ps

module tb_i2c_master_register_access;
   import i2cm_pkg::*;

   localparam logic [1:0] ACT_SPARE = 2'd3;  // decodes as a plain tick
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT = 100;
   localparam int RANDOM_WORDS = 200;

   typedef enum logic [3:0] {
      BUS_IDLE, BUS_START_A, BUS_START_B, BUS_START_C, BUS_BIT_LOW, BUS_BIT_HIGH,
      BUS_RESTART, BUS_STOP_A, BUS_STOP_B, BUS_STOP_C
   } bus_phase_type;

   typedef struct packed {
      bus_phase_type ph;
      logic [3:0]    bit_count;
      logic [7:0]    shift;
      logic [7:0]    timer;
      logic [2:0]    byte_step;
      logic          is_write;
      logic          ack_accum;
      logic [7:0]    read_byte;
      logic [7:0]    saved_reg;
      logic [7:0]    saved_value;
   } bus_state_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;

   i2c_master_register_access dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   cfg_type       bus_cfg;
   bus_state_type live_state;   // advanced on each accepted request word
   bus_state_type plan_state;   // advanced as words are queued
   rsp_type       plan_out;
   req_type       pending_ticks[$];
   rsp_type       expected_words[$];
   req_type       driven_item;
   int            fail_count = 0;
   int            planned = 0;
   int            burst_left = 0;
   int            gap_left = 0;
   int            idle_cycles = 0;
   int            stall_span = 0;
   int            stall_phase = 0;
   int            stall_mode = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void enter_byte(inout bus_state_type s, input logic [6:0] addr);
      case (s.byte_step)
         3'd0:    s.shift = {addr, RW_WRITE};
         3'd1:    s.shift = s.saved_reg;
         3'd2:    s.shift = s.is_write ? s.saved_value : {addr, RW_READ};
         default: s.shift = 8'd0;
      endcase
      s.bit_count = 4'd0;
      s.ph = BUS_BIT_LOW;
   endfunction

   // One tick of the bus sequencer: updates the state and returns the word it shows.
   function automatic rsp_type sequencer_tick(inout bus_state_type s, input cfg_type c,
                                              input req_type r);
      rsp_type    o;
      logic [7:0] lim;
      logic       rx;
      logic       done;
      lim = (c.half_period_ticks == 8'd0) ? 8'd1 : c.half_period_ticks;
      done = 1'b0;
      o = '0;
      if (s.ph == BUS_IDLE) begin
         if (r.action == ACT_READ || r.action == ACT_WRITE) begin
            s.is_write = (r.action == ACT_WRITE);
            s.saved_reg = r.reg_index;
            s.saved_value = r.write_value;
            s.byte_step = 3'd0;
            s.bit_count = 4'd0;
            s.ack_accum = 1'b1;
            s.timer = 8'd0;
            s.ph = BUS_START_A;
         end
      end else if (!(s.ph == BUS_BIT_HIGH && c.stretch_enable && !r.scl_sense)) begin
         s.timer = s.timer + 8'd1;
         if (s.timer >= lim) begin
            s.timer = 8'd0;
            rx = !s.is_write && s.byte_step == 3'd3;
            case (s.ph)
               BUS_START_A: s.ph = BUS_START_B;
               BUS_START_B: s.ph = BUS_START_C;
               BUS_START_C: enter_byte(s, c.device_address);
               BUS_BIT_LOW: s.ph = BUS_BIT_HIGH;
               BUS_BIT_HIGH: begin
                  if (s.bit_count < 4'd8) begin
                     s.shift = {s.shift[6:0], rx & r.sda_sense};
                     s.bit_count = s.bit_count + 4'd1;
                     s.ph = BUS_BIT_LOW;
                  end else if (rx) begin
                     s.read_byte = s.shift;
                     s.ph = BUS_STOP_A;
                  end else begin
                     if (s.is_write)
                        s.ack_accum = s.ack_accum & ~r.sda_sense;
                     s.byte_step = s.byte_step + 3'd1;
                     if (s.is_write && s.byte_step >= 3'd3)
                        s.ph = BUS_STOP_A;
                     else if (!s.is_write && s.byte_step == 3'd2)
                        s.ph = BUS_RESTART;
                     else
                        enter_byte(s, c.device_address);
                  end
               end
               BUS_RESTART: s.ph = BUS_START_A;
               BUS_STOP_A:  s.ph = BUS_STOP_B;
               BUS_STOP_B:  s.ph = BUS_STOP_C;
               default: begin
                  s.ph = BUS_IDLE;
                  done = 1'b1;
               end
            endcase
         end
      end
      rx = !s.is_write && s.byte_step == 3'd3;
      case (s.ph)
         BUS_START_B, BUS_STOP_B: o.sda_pull_low = 1'b1;
         BUS_START_C, BUS_STOP_A: begin
            o.scl_pull_low = 1'b1;
            o.sda_pull_low = 1'b1;
         end
         BUS_RESTART: o.scl_pull_low = 1'b1;
         BUS_BIT_LOW, BUS_BIT_HIGH: begin
            o.scl_pull_low = (s.ph == BUS_BIT_LOW);
            if (s.bit_count < 4'd8 && !rx)
               o.sda_pull_low = ~s.shift[7];
         end
         default: ;
      endcase
      o.busy_res = (s.ph != BUS_IDLE);
      o.done_res = done;
      o.read_value = s.read_byte;
      o.all_acked = s.ack_accum;
      return o;
   endfunction

   // Queues one tick word. Unless it is noise, the sensed levels follow the lines:
   // a line the master pulls low reads low, a released one is up to the slave.
   task automatic plan_item(input logic [1:0] act, input logic [7:0] reg_v,
                            input logic [7:0] val, input int sda_low_pct);
      req_type it;
      it.action = act;
      it.reg_index = reg_v;
      it.write_value = val;
      if ($urandom_range(0, 99) < 4) begin
         it.scl_sense = 1'($urandom_range(0, 1));
         it.sda_sense = 1'($urandom_range(0, 1));
      end else begin
         it.scl_sense = !plan_out.scl_pull_low && $urandom_range(0, 99) >= 25;
         it.sda_sense = !plan_out.sda_pull_low && $urandom_range(0, 99) >= sda_low_pct;
      end
      plan_out = sequencer_tick(plan_state, bus_cfg, it);
      pending_ticks.push_back(it);
      planned++;
   endtask

   task automatic plan_transaction(input logic [1:0] act, input logic [7:0] reg_v,
                                   input logic [7:0] val, input int sda_low_pct);
      logic [1:0] busy_act;
      plan_item(act, reg_v, val, sda_low_pct);
      while (plan_state.ph != BUS_IDLE) begin
         // Now and then a new command arrives while busy and must be ignored.
         busy_act = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) : ACT_TICK;
         plan_item(busy_act, 8'($urandom), 8'($urandom), sda_low_pct);
      end
   endtask

   task automatic wait_drained();
      while (pending_ticks.size() != 0 || req_tvalid || expected_words.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_DEVICE_ADDRESS: bus_cfg.device_address = data[6:0];
         CSR_STRETCH_ENABLE: bus_cfg.stretch_enable = data[0];
         CSR_HALF_PERIOD:    bus_cfg.half_period_ticks = data;
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [6:0] addr, input logic stretch,
                             input logic [7:0] half);
      wait_drained();
      write_reg(CSR_DEVICE_ADDRESS, {1'b0, addr});
      write_reg(CSR_STRETCH_ENABLE, {7'd0, stretch});
      write_reg(CSR_HALF_PERIOD, half);
   endtask

   function automatic int pick_sda_low_pct();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return 100;
         2:       return 90;
         default: return 50;
      endcase
   endfunction

   initial begin
      int         random_start;
      logic [6:0] addr;
      logic [7:0] half;
      bus_cfg = {7'd0, 1'b0, HALF_PERIOD_RESET};
      live_state = '0;
      live_state.ack_accum = 1'b1;
      plan_state = live_state;
      plan_out = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset configuration: idle ticks of both kinds, a fully acknowledged write
      // of the extreme register, then a read straight after it with every bit high.
      plan_item(ACT_SPARE, 8'h00, 8'h00, 50);
      plan_item(ACT_TICK, 8'hFF, 8'hFF, 50);
      plan_transaction(ACT_WRITE, 8'hFF, 8'h00, 100);
      plan_transaction(ACT_READ, 8'h00, 8'hFF, 0);

      // A zero half period counts as one tick.
      set_config(7'h7F, 1'b1, 8'd0);
      plan_transaction(ACT_READ, 8'hA5, 8'h5A, 100);
      plan_transaction(ACT_WRITE, 8'h5A, 8'hA5, 50);

      set_config(7'h2A, 1'b0, 8'd3);
      plan_transaction(ACT_WRITE, 8'h3C, 8'hC3, 90);

      random_start = planned;
      while (planned < random_start + RANDOM_WORDS) begin
         case ($urandom_range(0, 5))
            0:       addr = 7'h00;
            1:       addr = 7'h7F;
            default: addr = 7'($urandom);
         endcase
         half = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(3, 4))
                                            : 8'($urandom_range(0, 2));
         set_config(addr, 1'($urandom_range(0, 1)), half);
         repeat ($urandom_range(2, 4)) begin
            if (planned >= random_start + RANDOM_WORDS)
               break;
            repeat ($urandom_range(0, 3))
               plan_item($urandom_range(0, 1) ? ACT_TICK : ACT_SPARE,
                         8'($urandom), 8'($urandom), 50);
            plan_transaction($urandom_range(0, 1) ? ACT_READ : ACT_WRITE,
                             8'($urandom), 8'($urandom), pick_sda_low_pct());
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);  // responses trail requests through the request and response registers
      if (fail_count == 0)
         $display("tb_i2c_master_register_access: clean");
      else
         $display("tb_i2c_master_register_access: errors");
      $finish;
   end

   // Request driver: bursts of words separated by random gaps.
   always @(posedge clock) begin
      logic next_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         next_valid = req_tvalid;
         if (req_tvalid && req_tready) begin
            expected_words.push_back(sequencer_tick(live_state, bus_cfg, driven_item));
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
            end else if (pending_ticks.size() != 0) begin
               driven_item = pending_ticks.pop_front();
               req_tdata <= {6'd0, driven_item.sda_sense, driven_item.scl_sense,
                             driven_item.write_value, driven_item.reg_index};
               req_tuser <= driven_item.action;
               next_valid = 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                            : $urandom_range(1, 30);
                  gap_left <= $urandom_range(0, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end
         end
         req_tvalid <= next_valid;
      end
   end

   // Response back-pressure: the mode is picked at random among always ready, random stalls and a periodic stall.
   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_span <= $urandom_range(32, 300);
      end else begin
         stall_span <= stall_span - 1;
      end
      stall_phase <= (stall_phase == 4) ? 0 : stall_phase + 1;
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= ($urandom_range(0, 3) != 0);
         default: rsp_tready <= (stall_phase != 2);
      endcase
   end

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         if (fail_count < REPORT_LIMIT)
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_words.size() == 0) begin
            $display("%0t: response word expected none actual %0h", $time, rsp_tdata);
            fail_count++;
         end else begin
            want = expected_words.pop_front();
            check_field("scl_pull_low", 8'(want.scl_pull_low), 8'(rsp_tdata[0]));
            check_field("sda_pull_low", 8'(want.sda_pull_low), 8'(rsp_tdata[1]));
            check_field("busy_res", 8'(want.busy_res), 8'(rsp_tdata[2]));
            check_field("done_res", 8'(want.done_res), 8'(rsp_tdata[3]));
            check_field("read_value", want.read_value, rsp_tdata[11:4]);
            check_field("all_acked", 8'(want.all_acked), 8'(rsp_tdata[12]));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("tb_i2c_master_register_access: errors");
            $finish;
         end
      end
   end

endmodule
